// ----- design/rtd2t_pkg.sv -----
// shared types, constants and the temperature table of the pt100 converter
// no dependencies; used by every other file of the block
`default_nettype none

package rtd2t_pkg;

  // one table step is 10 ohm in 1/1024 ohm units
  localparam int unsigned STEP_Q = 10240;

  // field widths
  localparam int unsigned RES_W  = 18;
  localparam int unsigned K_W    = 5;
  localparam int unsigned F_W    = 16;
  localparam int unsigned T_W    = 20;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned DIFF_W = 22;

  // divide by ten: floor(x * 205 / 2^11), exact for 8-bit x
  localparam logic [15:0] RECIP10    = 16'd205;
  localparam int unsigned RECIP10_SH = 11;
  // divide by five: floor(x * 838861 / 2^22), exact for 19-bit x
  localparam logic [38:0] RECIP5     = 39'd838861;
  localparam int unsigned RECIP5_SH  = 22;

  // how a sample is handled by the back end
  typedef enum logic [1:0] {
    CLS_RANGE  = 2'd0,
    CLS_EXACT  = 2'd1,
    CLS_LINEAR = 2'd2,
    CLS_QUAD   = 2'd3
  } cls_e;

  // classified sample travelling through the queue
  typedef struct packed {
    cls_e             cls;
    logic [K_W-1:0]   k;
    logic [F_W-1:0]   frac;
  } item_t;

  // table word in millidegrees; entry i belongs to i*10 ohm
  function automatic logic signed [T_W-1:0] temp_word(input logic [IDX_W-1:0] idx);
    logic signed [T_W-1:0] w;
    case (idx)
      6'd0:    w = -20'sd500000;
      6'd1:    w = -20'sd219415;
      6'd2:    w = -20'sd196509;
      6'd3:    w = -20'sd173118;
      6'd4:    w = -20'sd149304;
      6'd5:    w = -20'sd125122;
      6'd6:    w = -20'sd100617;
      6'd7:    w = -20'sd75827;
      6'd8:    w = -20'sd50781;
      6'd9:    w = -20'sd25501;
      6'd10:   w = 20'sd0;
      6'd11:   w = 20'sd25686;
      6'd12:   w = 20'sd51571;
      6'd13:   w = 20'sd77660;
      6'd14:   w = 20'sd103958;
      6'd15:   w = 20'sd130469;
      6'd16:   w = 20'sd157198;
      6'd17:   w = 20'sd184152;
      6'd18:   w = 20'sd211336;
      6'd19:   w = 20'sd238756;
      6'd20:   w = 20'sd266419;
      default: w = 20'sd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- design/rtd2t_in_if.sv -----
// sample channel: valid/ready handshake carrying one resistance sample
// depends on rtd2t_pkg for the field width
`default_nettype none

interface rtd2t_in_if;
  logic                               valid;
  logic                               ready;
  logic [rtd2t_pkg::RES_W-1:0]        resistance_q;

  modport source (output valid, output resistance_q, input ready);
  modport sink   (input valid, input resistance_q, output ready);
endinterface

`default_nettype wire

// ----- design/rtd2t_out_if.sv -----
// result channel: valid/ready handshake carrying temperature and range flag
// depends on rtd2t_pkg for the field width
`default_nettype none

interface rtd2t_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rtd2t_pkg::T_W-1:0]   temperature_mdeg;
  logic                               out_of_range;

  modport source (output valid, output temperature_mdeg, output out_of_range, input ready);
  modport sink   (input valid, input temperature_mdeg, input out_of_range, output ready);
endinterface

`default_nettype wire

// ----- design/rtd2t_front.sv -----
// front end: splits a sample into span index and 16-bit fraction, classifies it
// depends on rtd2t_pkg and rtd2t_in_if
`default_nettype none

module rtd2t_front #(
  parameter int unsigned TABLE_ENTRIES = 21
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  rtd2t_in_if.sink                 in_i,
  output logic                     push_valid_o,
  input  wire logic                push_ready_i,
  output rtd2t_pkg::item_t         push_item_o
);

  localparam logic [19:0] QMAX = 20'((TABLE_ENTRIES - 1) * rtd2t_pkg::STEP_Q);
  localparam logic [rtd2t_pkg::IDX_W-1:0] KTOP = rtd2t_pkg::IDX_W'(TABLE_ENTRIES - 1);

  // whole ohms, divided by ten for the span index
  logic [7:0]                   units;
  logic [15:0]                  div_prod;
  logic [rtd2t_pkg::K_W-1:0]    k_calc;
  logic [7:0]                   k_x10;
  logic [7:0]                   rem_full;
  logic                         oor_calc;

  assign units    = in_i.resistance_q[17:10];
  assign div_prod = {8'b0, units} * rtd2t_pkg::RECIP10;
  assign k_calc   = div_prod[15:rtd2t_pkg::RECIP10_SH];
  assign k_x10    = {3'b0, k_calc} * 8'd10;
  assign rem_full = units - k_x10;
  assign oor_calc = ({2'b0, in_i.resistance_q} < 20'(rtd2t_pkg::STEP_Q))
                 || ({2'b0, in_i.resistance_q} > QMAX);

  // split stage registers
  logic                         valid_q;
  logic [rtd2t_pkg::K_W-1:0]    k_q;
  logic [3:0]                   rem_q;
  logic [9:0]                   low_q;
  logic                         oor_q;

  assign in_i.ready = !valid_q || push_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      k_q   <= k_calc;
      rem_q <= rem_full[3:0];
      low_q <= in_i.resistance_q[9:0];
      oor_q <= oor_calc;
    end
  end

  // fraction = floor(r * 32 / 5)
  logic [13:0]  rem_r;
  logic [18:0]  rem_x32;
  logic [38:0]  frac_prod;

  assign rem_r     = {rem_q, low_q};
  assign rem_x32   = {rem_r, 5'b0};
  assign frac_prod = {20'b0, rem_x32} * rtd2t_pkg::RECIP5;

  // classification of the span
  always_comb begin
    push_item_o.k    = k_q;
    push_item_o.frac = frac_prod[rtd2t_pkg::RECIP5_SH +: rtd2t_pkg::F_W];
    if (oor_q) begin
      push_item_o.cls = rtd2t_pkg::CLS_RANGE;
    end else if (rem_r == 14'd0 || {1'b0, k_q} >= KTOP) begin
      push_item_o.cls = rtd2t_pkg::CLS_EXACT;
    end else if (k_q == rtd2t_pkg::K_W'(1)) begin
      push_item_o.cls = rtd2t_pkg::CLS_LINEAR;
    end else begin
      push_item_o.cls = rtd2t_pkg::CLS_QUAD;
    end
  end

  assign push_valid_o = valid_q;

endmodule

`default_nettype wire

// ----- design/rtd2t_fifo.sv -----
// two-entry queue of classified samples between front and back end
// depends on rtd2t_pkg
`default_nettype none

module rtd2t_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_valid_i,
  output logic                     push_ready_o,
  input  rtd2t_pkg::item_t         push_item_i,
  output logic                     pop_valid_o,
  input  wire logic                pop_ready_i,
  output rtd2t_pkg::item_t         pop_item_o
);

  rtd2t_pkg::item_t  entry_q [2];
  logic              wr_ptr_q;
  logic              rd_ptr_q;
  logic [1:0]        count_q;
  logic              push;
  logic              pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entry_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/rtd2t_back.sv -----
// back end: table lookup, interpolation products, rounding and saturation
// depends on rtd2t_pkg and rtd2t_out_if
`default_nettype none

module rtd2t_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                pop_valid_i,
  output logic                     pop_ready_o,
  input  rtd2t_pkg::item_t         pop_item_i,
  rtd2t_out_if.source              out_o
);

  localparam int unsigned IW = rtd2t_pkg::IDX_W;
  localparam int unsigned TW = rtd2t_pkg::T_W;
  localparam int unsigned DW = rtd2t_pkg::DIFF_W;
  localparam int unsigned FW = rtd2t_pkg::F_W;

  logic rdy1;
  logic rdy2;
  logic rdy_out;

  // stage 1: table words, differences, fraction squared
  logic [IW-1:0]          idx_c;
  logic signed [TW-1:0]   word_p;
  logic signed [TW-1:0]   word_c;
  logic signed [TW-1:0]   word_n;
  logic signed [DW-1:0]   diff_calc;
  logic signed [DW-1:0]   curv_calc;
  logic [2*FW-1:0]        sq_calc;

  assign idx_c  = {1'b0, pop_item_i.k};
  assign word_c = rtd2t_pkg::temp_word(idx_c);
  assign word_p = rtd2t_pkg::temp_word(idx_c - IW'(1));
  assign word_n = rtd2t_pkg::temp_word(idx_c + IW'(1));

  always_comb begin
    if (pop_item_i.cls == rtd2t_pkg::CLS_LINEAR) begin
      diff_calc = DW'(word_n) - DW'(word_c);
    end else begin
      diff_calc = DW'(word_n) - DW'(word_p);
    end
  end

  assign curv_calc = DW'(word_p) - (DW'(word_c) <<< 1) + DW'(word_n);
  assign sq_calc   = {{FW{1'b0}}, pop_item_i.frac} * {{FW{1'b0}}, pop_item_i.frac};

  logic                   valid1_q;
  rtd2t_pkg::cls_e        cls1_q;
  logic [FW-1:0]          frac1_q;
  logic signed [TW-1:0]   base1_q;
  logic signed [DW-1:0]   diff1_q;
  logic signed [DW-1:0]   curv1_q;
  logic [2*FW-1:0]        sq1_q;

  assign pop_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else if (rdy1) begin
      valid1_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && rdy1) begin
      cls1_q  <= pop_item_i.cls;
      frac1_q <= pop_item_i.frac;
      base1_q <= word_c;
      diff1_q <= diff_calc;
      curv1_q <= curv_calc;
      sq1_q   <= sq_calc;
    end
  end

  // stage 2: slope and curvature products
  logic signed [FW+DW:0]     slope_calc;
  logic signed [2*FW+DW:0]   bend_calc;

  assign slope_calc = $signed({1'b0, frac1_q}) * diff1_q;
  assign bend_calc  = $signed({1'b0, sq1_q}) * curv1_q;

  logic                      valid2_q;
  rtd2t_pkg::cls_e           cls2_q;
  logic signed [TW-1:0]      base2_q;
  logic signed [FW+DW:0]     slope2_q;
  logic signed [2*FW+DW:0]   bend2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
    end else if (rdy2) begin
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid1_q && rdy2) begin
      cls2_q   <= cls1_q;
      base2_q  <= base1_q;
      slope2_q <= slope_calc;
      bend2_q  <= bend_calc;
    end
  end

  // stage 3: round, add to base word, saturate
  localparam int unsigned NW = 57;
  localparam int unsigned SW = 26;

  logic signed [NW-1:0]      quad_num;
  logic signed [NW-1:0]      quad_sh;
  logic signed [FW+DW:0]     lin_num;
  logic signed [FW+DW:0]     lin_sh;
  logic signed [SW-1:0]      temp_sum;
  logic signed [TW-1:0]      temp_sat;
  logic signed [TW-1:0]      temp_d;

  assign quad_num = (NW'(slope2_q) <<< 16) + NW'(bend2_q) + (NW'(1) <<< 32);
  assign quad_sh  = quad_num >>> 33;
  assign lin_num  = slope2_q + (FW+DW+1)'(32768);
  assign lin_sh   = lin_num >>> 16;

  always_comb begin
    if (cls2_q == rtd2t_pkg::CLS_LINEAR) begin
      temp_sum = SW'(base2_q) + SW'(lin_sh);
    end else begin
      temp_sum = SW'(base2_q) + SW'(quad_sh);
    end
    if (temp_sum > SW'(524287)) begin
      temp_sat = TW'(524287);
    end else if (temp_sum < -SW'(524288)) begin
      temp_sat = -TW'(524288);
    end else begin
      temp_sat = TW'(temp_sum);
    end
  end

  always_comb begin
    case (cls2_q)
      rtd2t_pkg::CLS_RANGE:  temp_d = '0;
      rtd2t_pkg::CLS_EXACT:  temp_d = base2_q;
      rtd2t_pkg::CLS_LINEAR: temp_d = temp_sat;
      rtd2t_pkg::CLS_QUAD:   temp_d = temp_sat;
      default:               temp_d = '0;
    endcase
  end

  // output register
  logic                   valid_o_q;
  logic signed [TW-1:0]   temp_q;
  logic                   oor_q;

  assign rdy_out = !valid_o_q || out_o.ready;
  assign rdy2    = !valid2_q || rdy_out;
  assign rdy1    = !valid1_q || rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o_q <= 1'b0;
    end else if (rdy_out) begin
      valid_o_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid2_q && rdy_out) begin
      temp_q <= temp_d;
      oor_q  <= (cls2_q == rtd2t_pkg::CLS_RANGE);
    end
  end

  assign out_o.valid            = valid_o_q;
  assign out_o.temperature_mdeg = temp_q;
  assign out_o.out_of_range     = oor_q;

endmodule

`default_nettype wire

// ----- design/rtd_resistance_to_temperature.sv -----
// PT100 resistance to temperature converter, one sample per clock when the
// result side keeps up. A sample (1/1024 ohm) is accepted when valid and ready
// are high; the result (millidegrees Celsius, or zero with out_of_range set
// below 10 ohm or above (TABLE_ENTRIES-1)*10 ohm) passes through one split
// register in the front end, one queue slot, then table, product and rounding
// stages in the back end. The pipeline is paced by its two multiplier stages in
// the back end, each taking one sample per cycle while the result side keeps up;
// a stalled result side fills the two-entry queue before the sample input drops ready.
// depends on rtd2t_pkg, rtd2t_in_if, rtd2t_out_if, rtd2t_front, rtd2t_fifo, rtd2t_back
`default_nettype none

module rtd_resistance_to_temperature #(
  parameter int unsigned TABLE_ENTRIES = 21
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  rtd2t_in_if.sink     in_i,
  rtd2t_out_if.source  out_o
);

  localparam logic [rtd2t_pkg::IDX_W-1:0] KTOP = rtd2t_pkg::IDX_W'(TABLE_ENTRIES - 1);

  logic              q_push_valid;
  logic              q_push_ready;
  rtd2t_pkg::item_t  q_push_item;
  logic              q_pop_valid;
  logic              q_pop_ready;
  rtd2t_pkg::item_t  q_pop_item;

  // span split and classification
  rtd2t_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (q_push_valid),
    .push_ready_i (q_push_ready),
    .push_item_o  (q_push_item)
  );

  // decoupling queue
  rtd2t_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_item_i  (q_push_item),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_item_o   (q_pop_item)
  );

  // interpolation pipeline
  rtd2t_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_valid),
    .pop_ready_o (q_pop_ready),
    .pop_item_i  (q_pop_item),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  // an out-of-range result carries a zero temperature
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.out_of_range |-> out_o.temperature_mdeg == '0)
    else $error("out-of-range result with nonzero temperature");

  // linear interpolation only in the first usable span
  a_linear_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_valid && q_push_ready && q_push_item.cls == rtd2t_pkg::CLS_LINEAR
    |-> q_push_item.k == rtd2t_pkg::K_W'(1) && q_push_item.frac != '0)
    else $error("linear class outside the first span");

  // quadratic spans have a lower and an upper neighbor and a nonzero fraction
  a_quad_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_valid && q_push_ready && q_push_item.cls == rtd2t_pkg::CLS_QUAD
    |-> q_push_item.k >= rtd2t_pkg::K_W'(2) && {1'b0, q_push_item.k} < KTOP
        && q_push_item.frac != '0)
    else $error("quadratic class outside the inner spans");
`endif

endmodule

`default_nettype wire
